// File: sv/gh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_pkg
// Shared types and codes of the generational handle pool.
// ----------------------------------------------------------------------------
package gh_pkg;

  localparam int HANDLE_W = 32;
  localparam int GEN_W    = 16;
  localparam int HIDX_W   = 16;
  localparam int CFG_W    = 11;
  localparam int SLOT_W   = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_MAX  = (1 << CFG_W) - 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic                opcode;
    logic [HANDLE_W-1:0] handle_in;
  } in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [SLOT_W-1:0]   slot_id;
    logic                slot_allocated;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic             rebuild;
    logic             push;
    logic             pop;
    logic [CFG_W-1:0] push_idx;
    logic [CFG_W-1:0] pool;
  } stk_cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] top;
    logic [CFG_W-1:0] count;
    logic [CFG_W-1:0] pool;
  } stk_stat_t;

endpackage

// File: sv/gh_free_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_free_stack
// Free slot stack in a synchronous memory. Entries below the lowest depth
// reached since the last rebuild still hold their rebuild value, which is
// computed instead of read.
// ----------------------------------------------------------------------------
module gh_free_stack #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic              clk,
  input  gh_pkg::stk_cmd_t  cmd,
  output gh_pkg::stk_stat_t stat
);

  localparam int SA_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic [gh_pkg::CFG_W-1:0] mem [MAX_ITEMS];
  logic [gh_pkg::CFG_W-1:0] rd_q;
  logic [gh_pkg::CFG_W-1:0] count;
  logic [gh_pkg::CFG_W-1:0] min_cnt;
  logic [gh_pkg::CFG_W-1:0] pool;
  logic [gh_pkg::CFG_W-1:0] count_dec;

  assign count_dec = count - 1'b1;

  always_ff @(posedge clk) begin
    rd_q <= mem[SA_W'(count_dec)];
    if (cmd.push) begin
      mem[SA_W'(count)] <= cmd.push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rebuild) begin
      pool    <= cmd.pool;
      count   <= cmd.pool;
      min_cnt <= cmd.pool;
    end else if (cmd.pop) begin
      count <= count_dec;
      if (count_dec < min_cnt) begin
        min_cnt <= count_dec;
      end
    end else if (cmd.push) begin
      count <= count + 1'b1;
    end
  end

  always_comb begin
    stat.count = count;
    stat.pool  = pool;
    stat.top   = (count > min_cnt) ? rd_q : pool - count + 1'b1;
  end

endmodule

// File: sv/gh_gen_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gh_gen_table
// Per-slot generation counters in a synchronous memory, with a clearing
// sweep over all entries, one after another, after reset and on each rebuild.
// ----------------------------------------------------------------------------
module gh_gen_table #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear_start,
  output logic                     busy,
  input  logic                     rd_en,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] rd_addr,
  output logic [gh_pkg::GEN_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] wr_addr,
  input  logic [gh_pkg::GEN_W-1:0] wr_data
);

  localparam int GA_W = $clog2(MAX_ITEMS + 1);

  logic [gh_pkg::GEN_W-1:0] mem [MAX_ITEMS+1];
  logic [GA_W-1:0]          clr_addr;

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == GA_W'(MAX_ITEMS)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

endmodule

// File: sv/generational_handle_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_pool
// Slot allocator handing out generational handles from a free stack.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall with in_data (opcode, handle_in);
// results leave on out_valid/out_stall with out_data, one per request, in
// order. An alloc pops the top free slot, bumps its generation and returns
// {generation, index}; a free pushes the index of handle_in back if it is valid.
// A request is accepted at an edge with in_valid high and in_stall low.
// A free, or an alloc that finds the stack empty, passes through S_EXEC and
// S_OUT after acceptance, any other alloc through S_EXEC, S_GEN and S_OUT: the
// stack step on the registered stack read, the registered generation read
// (alloc only) and the output register. One request is in flight at a time;
// no new request is accepted until the last one has left S_OUT.
// The next request is accepted while a result still waits in the output
// register; a stalled receiver holds out_data and, once the following
// result is ready, holds the block as well.
// cfg_wr_en/cfg_wr_data set the pool size (0 reads as 1, clamped above),
// rebuild the free stack and clear all generations. After reset and after
// each size write a clearing pass runs over all MAX_ITEMS+1 entries of the
// generation memory; in_stall stays high until it ends.
// ----------------------------------------------------------------------------
module generational_handle_pool #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  gh_pkg::in_t              in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output gh_pkg::out_t             out_data,
  input  logic                     cfg_wr_en,
  input  logic [gh_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int GA_W     = $clog2(MAX_ITEMS + 1);
  localparam int POOL_MAX = (MAX_ITEMS > gh_pkg::CFG_MAX) ? gh_pkg::CFG_MAX : MAX_ITEMS;
  localparam int POOL_RST = (1024 > POOL_MAX) ? POOL_MAX : 1024;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_GEN, S_OUT} state_t;

  state_t                   state;
  gh_pkg::in_t              req;
  gh_pkg::out_t             res;
  gh_pkg::out_t             exec_res;
  logic [gh_pkg::CFG_W-1:0] alloc_idx;
  logic                     load_out;
  logic                     out_valid_next;

  gh_pkg::stk_cmd_t         stk_cmd;
  gh_pkg::stk_stat_t        stk;
  logic                     gen_busy;
  logic [gh_pkg::GEN_W-1:0] gen_rd;
  logic [gh_pkg::GEN_W-1:0] gen_inc;
  logic [gh_pkg::HIDX_W-1:0] free_idx;
  logic                     free_ok;
  logic                     is_alloc;

  function automatic logic [gh_pkg::CFG_W-1:0] clamp_pool(input logic [gh_pkg::CFG_W-1:0] v);
    logic [gh_pkg::CFG_W-1:0] n;
    n = v;
    if (v == '0) begin
      n = gh_pkg::CFG_W'(1);
    end else if (v > gh_pkg::CFG_W'(POOL_MAX)) begin
      n = gh_pkg::CFG_W'(POOL_MAX);
    end
    return n;
  endfunction

  assign in_stall = gen_busy || (state != S_IDLE);
  assign is_alloc = (req.opcode == gh_pkg::OP_ALLOC);
  assign free_idx = req.handle_in[gh_pkg::HIDX_W-1:0];
  assign free_ok  = (free_idx != '0) && (free_idx <= gh_pkg::HIDX_W'(stk.pool))
                    && (stk.count < stk.pool);
  assign gen_inc  = gen_rd + 1'b1;

  assign load_out       = (state == S_OUT) && (!out_valid || !out_stall);
  assign out_valid_next = load_out || (out_valid && out_stall);

  always_comb begin
    stk_cmd.rebuild  = rst || cfg_wr_en;
    stk_cmd.pool     = rst ? gh_pkg::CFG_W'(POOL_RST) : clamp_pool(cfg_wr_data);
    stk_cmd.pop      = !rst && (state == S_EXEC) && is_alloc && (stk.count != '0);
    stk_cmd.push     = !rst && (state == S_EXEC) && !is_alloc && free_ok;
    stk_cmd.push_idx = gh_pkg::CFG_W'(free_idx);
  end

  always_comb begin
    exec_res        = '0;
    exec_res.status = gh_pkg::ST_OK;
    if (is_alloc) begin
      if (stk.count == '0) begin
        exec_res.status = gh_pkg::ST_EMPTY;
      end
    end else if (free_ok) begin
      exec_res.slot_id = gh_pkg::SLOT_W'(free_idx);
    end else begin
      exec_res.status = gh_pkg::ST_REJECT;
    end
  end

  gh_free_stack #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_stack (
    .clk (clk),
    .cmd (stk_cmd),
    .stat(stk)
  );

  gh_gen_table #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_gen (
    .clk        (clk),
    .rst        (rst),
    .clear_start(cfg_wr_en),
    .busy       (gen_busy),
    .rd_en      (state == S_EXEC),
    .rd_addr    (GA_W'(stk.top)),
    .rd_data    (gen_rd),
    .wr_en      (state == S_GEN),
    .wr_addr    (GA_W'(alloc_idx)),
    .wr_data    (gen_inc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req   <= in_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res       <= exec_res;
          alloc_idx <= stk.top;
          if (is_alloc && (stk.count != '0)) begin
            state <= S_GEN;
          end else begin
            state <= S_OUT;
          end
        end
        S_GEN: begin
          res.handle_out     <= {gen_inc, gh_pkg::HIDX_W'(alloc_idx)};
          res.slot_id        <= gh_pkg::SLOT_W'(alloc_idx);
          res.slot_allocated <= 1'b1;
          state              <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    gen_busy |-> in_stall)
    else $error("request accepted during generation clear");

  a_alloc_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.slot_allocated |->
      (out_data.status == gh_pkg::ST_OK) && (out_data.slot_id != '0))
    else $error("allocated result without ok status or slot");

  a_gen_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_GEN) |-> ($past(state) == S_EXEC))
    else $error("generation step not preceded by stack step");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> (stk.count <= stk.pool))
    else $error("free stack count above pool size");

endmodule
